FILE: hw/rtl/asoa_pkg.sv
// Shared types and constants for the ADC scan oversampling averager.
// Used by asoa_core and the top level; depends on nothing else.
package asoa_pkg;

  // Field widths fixed by the stream format
  localparam int ADC_W  = 10;
  localparam int CHAN_W = 2;
  localparam int AVG_W  = 12;

  // Saturation limit of the reported average
  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  // Request kinds carried on in_tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_BUTTON = 1'b1;

  // Default configuration of the averager
  localparam int DEF_NUM_CHANNELS      = 4;
  localparam int DEF_SAMPLES_PER_GROUP = 16;
  localparam int DEF_GROUPS_PER_RESULT = 5;
  localparam int DEF_GROUP_SHIFT       = 2;

  // One result transaction, as produced by the core
  typedef struct packed {
    logic              value_valid;
    logic [CHAN_W-1:0] result_channel;
    logic [AVG_W-1:0]  average_value;
    logic              scan_enabled;
    logic              green_led;
    logic              red_led;
    logic              ready_line;
    logic [CHAN_W-1:0] mux_channel;
  } asoa_result_t;

endpackage

FILE: hw/rtl/adc_scan_oversampling_averager_unit.sv
// An accepted input transaction reaches out_tvalid through the input register, then the
// result register. Throughput: one transaction per cycle while out_tready does not stall
// the output, set by the state update in asoa_core between those two registers.
// Reset (rst_n low, synchronous): both pipeline stages empty, scanning off, LEDs off,
// channel 0, first sample of the channel marked for discard.
// Top level of the ADC scan oversampling averager; depends on asoa_pkg and asoa_core.
module adc_scan_oversampling_averager_unit #(
  parameter int NUM_CHANNELS      = asoa_pkg::DEF_NUM_CHANNELS,
  parameter int SAMPLES_PER_GROUP = asoa_pkg::DEF_SAMPLES_PER_GROUP,
  parameter int GROUPS_PER_RESULT = asoa_pkg::DEF_GROUPS_PER_RESULT,
  parameter int GROUP_SHIFT       = asoa_pkg::DEF_GROUP_SHIFT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] adc_value, [10] supply_ok, [15:11] zero
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] result_channel, [13:2] average_value,
                                  // [14] scan_enabled, [15] green_led, [16] red_led,
                                  // [17] ready_line, [19:18] mux_channel, [23:20] zero
  output logic [0:0]  out_tuser   // [0] value_valid
);
  import asoa_pkg::*;

  logic              s1_valid_r;
  logic              s1_req_r;
  logic [ADC_W-1:0]  s1_adc_r;
  logic              s1_ok_r;
  logic              out_valid_r;
  asoa_result_t      out_res_r;
  asoa_result_t      core_res;
  logic              out_free;
  logic              step;

  // Pipeline flow: the result register frees when empty or taken
  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r <= in_tuser[0];
      s1_adc_r <= in_tdata[ADC_W-1:0];
      s1_ok_r  <= in_tdata[ADC_W];
    end
  end

  asoa_core #(
    .NUM_CHANNELS      (NUM_CHANNELS),
    .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
    .GROUPS_PER_RESULT (GROUPS_PER_RESULT),
    .GROUP_SHIFT       (GROUP_SHIFT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .req_type  (s1_req_r),
    .adc_value (s1_adc_r),
    .supply_ok (s1_ok_r),
    .res       (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= core_res;
    end
  end

  // Pack the result transaction
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.value_valid;
  assign out_tdata  = {4'b0000,
                       out_res_r.mux_channel,
                       out_res_r.ready_line,
                       out_res_r.red_led,
                       out_res_r.green_led,
                       out_res_r.scan_enabled,
                       out_res_r.average_value,
                       out_res_r.result_channel};

endmodule

FILE: hw/rtl/asoa_core.sv
// Scan state, group accumulation and the divide-by-group-count of the averager.
// Depends on asoa_pkg; state advances on each step strobe from the top level.
module asoa_core #(
  parameter int NUM_CHANNELS      = asoa_pkg::DEF_NUM_CHANNELS,
  parameter int SAMPLES_PER_GROUP = asoa_pkg::DEF_SAMPLES_PER_GROUP,
  parameter int GROUPS_PER_RESULT = asoa_pkg::DEF_GROUPS_PER_RESULT,
  parameter int GROUP_SHIFT       = asoa_pkg::DEF_GROUP_SHIFT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          req_type,
  input  logic [asoa_pkg::ADC_W-1:0]    adc_value,
  input  logic                          supply_ok,
  output asoa_pkg::asoa_result_t        res
);
  import asoa_pkg::*;

  localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SCNT_W      = $clog2(SAMPLES_PER_GROUP + 1);
  localparam int GCNT_W      = $clog2(GROUPS_PER_RESULT + 1);
  localparam int GSUM_W      = ADC_W + SCNT_W;
  localparam int TOTAL_W     = GSUM_W - GROUP_SHIFT + GCNT_W;
  // Exact reciprocal divide: floor(t / d) = (t * ceil(2^S / d)) >> S for t < 2^TOTAL_W
  localparam int DIV_SHIFT   = TOTAL_W + $clog2(GROUPS_PER_RESULT);
  localparam int MULT_W      = DIV_SHIFT + 1;
  localparam int PROD_W      = TOTAL_W + MULT_W;
  localparam longint DIV_MULT_L =
    ((64'd1 << DIV_SHIFT) + GROUPS_PER_RESULT - 1) / GROUPS_PER_RESULT;
  localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);

  logic              enable_r,   enable_nxt;
  logic              first_run_r, first_run_nxt;
  logic              green_r,    green_nxt;
  logic              red_r,      red_nxt;
  logic              ready_r,    ready_nxt;
  logic [CH_W-1:0]   chan_r,     chan_nxt;
  logic              discard_r,  discard_nxt;
  logic [SCNT_W-1:0] scnt_r,     scnt_nxt;
  logic [GCNT_W-1:0] gcnt_r,     gcnt_nxt;
  logic [GSUM_W-1:0] gsum_r,     gsum_nxt;
  logic [TOTAL_W-1:0] total_r,   total_nxt;

  logic [GSUM_W-1:0]       gsum_add;
  logic [SCNT_W-1:0]       scnt_inc;
  logic [GCNT_W-1:0]       gcnt_inc;
  logic [TOTAL_W-1:0]      total_add;
  logic [PROD_W-1:0]       product;
  logic [TOTAL_W+AVG_W-1:0] quot_ext;
  logic [CH_W+CHAN_W-1:0]  chan_cur_ext;
  logic [CH_W+CHAN_W-1:0]  chan_nxt_ext;
  logic                    avg_valid;
  logic [AVG_W-1:0]        avg_val;

  // Datapath terms shared by the update below
  assign gsum_add  = gsum_r + GSUM_W'(adc_value);
  assign scnt_inc  = scnt_r + SCNT_W'(1);
  assign gcnt_inc  = gcnt_r + GCNT_W'(1);
  assign total_add = total_r + TOTAL_W'(gsum_add >> GROUP_SHIFT);
  assign product   = PROD_W'(total_add) * PROD_W'(DIV_MULT);
  assign quot_ext  = (TOTAL_W+AVG_W)'(product >> DIV_SHIFT);

  // Next-state logic for one item
  always_comb begin
    enable_nxt    = enable_r;
    first_run_nxt = first_run_r;
    green_nxt     = green_r;
    red_nxt       = red_r;
    ready_nxt     = ready_r;
    chan_nxt      = chan_r;
    discard_nxt   = discard_r;
    scnt_nxt      = scnt_r;
    gcnt_nxt      = gcnt_r;
    gsum_nxt      = gsum_r;
    total_nxt     = total_r;
    avg_valid     = 1'b0;
    avg_val       = '0;

    if (!supply_ok) begin
      // Supply lost: stop scanning and drop partial work
      enable_nxt    = 1'b0;
      green_nxt     = 1'b0;
      red_nxt       = 1'b0;
      ready_nxt     = 1'b1;
      first_run_nxt = 1'b1;
      discard_nxt   = 1'b1;
      scnt_nxt      = '0;
      gcnt_nxt      = '0;
      gsum_nxt      = '0;
      total_nxt     = '0;
    end else begin
      if (first_run_r) begin
        green_nxt     = 1'b1;
        red_nxt       = 1'b0;
        ready_nxt     = 1'b0;
        first_run_nxt = 1'b0;
      end
      if (req_type == REQ_SAMPLE) begin
        if (enable_r) begin
          if (discard_r) begin
            discard_nxt = 1'b0;
          end else if (scnt_inc >= SCNT_W'(SAMPLES_PER_GROUP)) begin
            // Group complete: fold it into the running total
            if (gcnt_inc >= GCNT_W'(GROUPS_PER_RESULT)) begin
              avg_valid   = 1'b1;
              avg_val     = (quot_ext > (TOTAL_W+AVG_W)'(AVG_MAX)) ?
                            AVG_MAX : quot_ext[AVG_W-1:0];
              chan_nxt    = (chan_r == CH_W'(NUM_CHANNELS - 1)) ?
                            '0 : chan_r + CH_W'(1);
              discard_nxt = 1'b1;
              scnt_nxt    = '0;
              gcnt_nxt    = '0;
              gsum_nxt    = '0;
              total_nxt   = '0;
            end else begin
              total_nxt = total_add;
              gcnt_nxt  = gcnt_inc;
              gsum_nxt  = '0;
              scnt_nxt  = '0;
            end
          end else begin
            gsum_nxt = gsum_add;
            scnt_nxt = scnt_inc;
          end
        end
      end else begin
        // Button press: toggle scanning and abort any partial average
        enable_nxt  = ~enable_r;
        green_nxt   = ~green_nxt;
        red_nxt     = ~red_nxt;
        discard_nxt = 1'b1;
        scnt_nxt    = '0;
        gcnt_nxt    = '0;
        gsum_nxt    = '0;
        total_nxt   = '0;
      end
    end
  end

  // Channel fields are reported in two bits
  assign chan_cur_ext = (CH_W+CHAN_W)'(chan_r);
  assign chan_nxt_ext = (CH_W+CHAN_W)'(chan_nxt);

  always_comb begin
    res.value_valid    = avg_valid;
    res.result_channel = avg_valid ? chan_cur_ext[CHAN_W-1:0] : '0;
    res.average_value  = avg_val;
    res.scan_enabled   = enable_nxt;
    res.green_led      = green_nxt;
    res.red_led        = red_nxt;
    res.ready_line     = ready_nxt;
    res.mux_channel    = chan_nxt_ext[CHAN_W-1:0];
  end

  // State registers, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      first_run_r <= 1'b1;
      green_r     <= 1'b0;
      red_r       <= 1'b0;
      ready_r     <= 1'b0;
      chan_r      <= '0;
      discard_r   <= 1'b1;
      scnt_r      <= '0;
      gcnt_r      <= '0;
      gsum_r      <= '0;
      total_r     <= '0;
    end else if (step) begin
      enable_r    <= enable_nxt;
      first_run_r <= first_run_nxt;
      green_r     <= green_nxt;
      red_r       <= red_nxt;
      ready_r     <= ready_nxt;
      chan_r      <= chan_nxt;
      discard_r   <= discard_nxt;
      scnt_r      <= scnt_nxt;
      gcnt_r      <= gcnt_nxt;
      gsum_r      <= gsum_nxt;
      total_r     <= total_nxt;
    end
  end

endmodule

FILE: hw/rtl/asoa_checker.sv
// Port-level checks for the ADC scan oversampling averager, bound to the top level.
// Depends only on the top-level ports.
module asoa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result transaction changed while stalled");

  // A completed average leaves scanning enabled
  a_avg_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[14])
    else $error("average reported while scanning disabled");

  // Without an average, channel and value read zero
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[13:0] == 14'd0)
    else $error("nonzero average fields without a completed average");

  // Red LED tracks the scan enable
  a_red_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16] == out_tdata[14])
    else $error("red LED differs from scan enable");

  // Ready line only while everything is off
  a_ready_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> !out_tdata[14] && !out_tdata[15] && !out_tdata[16])
    else $error("ready line high with scanning or LEDs on");

endmodule

bind adc_scan_oversampling_averager_unit asoa_checker u_asoa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: verif/tb_adc_scan_oversampling_averager_unit.sv
// Self-checking testbench for adc_scan_oversampling_averager_unit: streams converter
// samples, button events and supply drops, predicts every result transaction and compares.
// Depends on asoa_pkg and the RTL of the averager; needs no files or arguments.
module tb_adc_scan_oversampling_averager_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import asoa_pkg::*;

  localparam int NUM_CH       = DEF_NUM_CHANNELS;
  localparam int GROUP_LEN    = DEF_SAMPLES_PER_GROUP;
  localparam int GROUP_COUNT  = DEF_GROUPS_PER_RESULT;
  localparam int GROUP_SHR    = DEF_GROUP_SHIFT;
  localparam int BURST_LEN    = GROUP_LEN * GROUP_COUNT + 1;  // leading discard included
  localparam int GROUP_ACC_W  = ADC_W + $clog2(GROUP_LEN);
  localparam int TOTAL_ACC_W  = GROUP_ACC_W - GROUP_SHR + $clog2(GROUP_COUNT + 1);
  localparam int ITEM_TARGET  = 2000;
  localparam int MIN_AVERAGES = 10;
  localparam int HOLD_CYCLES  = 200;

  typedef struct packed {
    logic             kind;
    logic [ADC_W-1:0] adc_code;
    logic             supply_good;
  } scan_req_t;

  typedef enum logic [1:0] {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [9:0] adc_value, [10] supply_ok, [15:11] zero
  logic [0:0]  in_tuser = '0;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [1:0] result_channel, [13:2] average_value,
                                // [14] scan_enabled, [15] green_led, [16] red_led,
                                // [17] ready_line, [19:18] mux_channel, [23:20] zero
  logic [0:0]  out_tuser;       // [0] value_valid

  // Stimulus and expectation stores
  scan_req_t    requests_to_send[$];
  asoa_result_t reports_due[$];
  scan_req_t    offered_req;
  int unsigned  total_requests = 0;
  int unsigned  accepted_count = 0;
  int unsigned  mismatch_count = 0;
  logic         hold_off = 1'b0;

  // Planning view of the scanner, used only to shape the stimulus
  logic         plan_scanning = 1'b0;
  int unsigned  plan_progress = 0;
  int unsigned  plan_averages = 0;
  int unsigned  effective_count = 0;

  // Predicted scanner state
  logic                          scan_on = 1'b0;
  logic                          fresh_power = 1'b1;
  logic                          green_on = 1'b0;
  logic                          red_on = 1'b0;
  logic                          ready_on = 1'b0;
  logic [CHAN_W-1:0]             scan_chan = '0;
  logic                          skip_next = 1'b1;
  logic [$clog2(GROUP_LEN+1)-1:0]   sample_cnt = '0;
  logic [$clog2(GROUP_COUNT+1)-1:0] group_cnt = '0;
  logic [GROUP_ACC_W-1:0]        group_acc = '0;
  logic [TOTAL_ACC_W-1:0]        total_acc = '0;

  adc_scan_oversampling_averager_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Drop any partial average and arm the discard of the next sample
  task automatic restart_average();
    skip_next  = 1'b1;
    sample_cnt = '0;
    group_cnt  = '0;
    group_acc  = '0;
    total_acc  = '0;
  endtask

  // Advance the predicted scanner by one accepted transaction and queue its report
  task automatic advance_scanner(input scan_req_t req);
    asoa_result_t rep;
    int unsigned  quotient;
    rep = '0;
    if (!req.supply_good) begin
      scan_on     = 1'b0;
      green_on    = 1'b0;
      red_on      = 1'b0;
      ready_on    = 1'b1;
      fresh_power = 1'b1;
      restart_average();
    end else begin
      if (fresh_power) begin
        green_on    = 1'b1;
        red_on      = 1'b0;
        ready_on    = 1'b0;
        fresh_power = 1'b0;
      end
      if (req.kind == REQ_SAMPLE) begin
        if (scan_on) begin
          if (skip_next) begin
            skip_next = 1'b0;
          end else begin
            group_acc  = group_acc + req.adc_code;
            sample_cnt = sample_cnt + 1'b1;
            if (sample_cnt >= GROUP_LEN) begin
              total_acc  = total_acc + (group_acc >> GROUP_SHR);
              group_acc  = '0;
              sample_cnt = '0;
              group_cnt  = group_cnt + 1'b1;
              if (group_cnt >= GROUP_COUNT) begin
                quotient = total_acc / GROUP_COUNT;
                rep.value_valid    = 1'b1;
                rep.average_value  = (quotient > AVG_MAX) ? AVG_MAX : quotient[AVG_W-1:0];
                rep.result_channel = scan_chan;
                scan_chan = (scan_chan == NUM_CH - 1) ? '0 : scan_chan + 1'b1;
                restart_average();
              end
            end
          end
        end
      end else begin
        scan_on  = ~scan_on;
        green_on = ~green_on;
        red_on   = ~red_on;
        restart_average();
      end
    end
    rep.scan_enabled = scan_on;
    rep.green_led    = green_on;
    rep.red_led      = red_on;
    rep.ready_line   = ready_on;
    rep.mux_channel  = scan_chan;
    reports_due.push_back(rep);
  endtask

  // Queue one request and track how far it takes the planned scan
  task automatic push_request(input logic kind, input logic [ADC_W-1:0] code,
                              input logic good);
    scan_req_t req;
    req.kind        = kind;
    req.adc_code    = code;
    req.supply_good = good;
    requests_to_send.push_back(req);
    if (!good) begin
      plan_scanning = 1'b0;
      plan_progress = 0;
      effective_count++;
    end else if (kind == REQ_BUTTON) begin
      plan_scanning = !plan_scanning;
      plan_progress = 0;
      effective_count++;
    end else if (plan_scanning) begin
      effective_count++;
      plan_progress++;
      if (plan_progress == BURST_LEN) begin
        plan_progress = 0;
        plan_averages++;
      end
    end
  endtask

  // Pick one converter code following the shape chosen for a burst
  function automatic logic [ADC_W-1:0] burst_code(input int shape, input int level,
                                                  input int idx);
    logic [ADC_W-1:0] code;
    case (shape)
      0:       code = ADC_W'($urandom_range(1023));
      1:       code = '1;
      2:       code = '0;
      3:       code = ADC_W'(level + $urandom_range(15));
      default: code = idx[0] ? '1 : '0;
    endcase
    return code;
  endfunction

  // Queue a run of samples with one random shape
  task automatic push_burst(input int len);
    int shape, level;
    shape = $urandom_range(4);
    level = $urandom_range(1023);
    for (int i = 0; i < len; i++) push_request(REQ_SAMPLE, burst_code(shape, level, i), 1'b1);
  endtask

  function automatic idle_phase_t current_phase();
    if (total_requests == 0 || accepted_count * 3 < total_requests) return IDLE_RX_HEAVY;
    if (accepted_count * 3 < total_requests * 2) return IDLE_TX_HEAVY;
    return IDLE_NONE;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // Present requests; predict each one as its transaction completes
  always @(posedge clk) begin : request_driver
    logic still_offered;
    int   idle_pct;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      still_offered = in_tvalid;
      if (in_tvalid && in_tready) begin
        advance_scanner(offered_req);
        accepted_count++;
        still_offered = 1'b0;
      end
      case (current_phase())
        IDLE_RX_HEAVY: idle_pct = 22;
        IDLE_TX_HEAVY: idle_pct = 52;
        default:       idle_pct = 0;
      endcase
      if (!still_offered) begin
        if (requests_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offered_req = requests_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, offered_req.supply_good, offered_req.adc_code};
          in_tuser  <= offered_req.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Take results and compare them with the oldest prediction
  always @(posedge clk) begin : result_monitor
    asoa_result_t want;
    int           stall_pct;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reports_due.size() == 0) begin
          $error("result transaction with no prediction pending: tdata %h", out_tdata);
          mismatch_count++;
        end else begin
          want = reports_due.pop_front();
          compare_field("value_valid",    16'(want.value_valid),    16'(out_tuser[0]));
          compare_field("result_channel", 16'(want.result_channel), 16'(out_tdata[1:0]));
          compare_field("average_value",  16'(want.average_value),  16'(out_tdata[13:2]));
          compare_field("scan_enabled",   16'(want.scan_enabled),   16'(out_tdata[14]));
          compare_field("green_led",      16'(want.green_led),      16'(out_tdata[15]));
          compare_field("red_led",        16'(want.red_led),        16'(out_tdata[16]));
          compare_field("ready_line",     16'(want.ready_line),     16'(out_tdata[17]));
          compare_field("mux_channel",    16'(want.mux_channel),    16'(out_tdata[19:18]));
        end
      end
      case (current_phase())
        IDLE_RX_HEAVY: stall_pct = 52;
        IDLE_TX_HEAVY: stall_pct = 22;
        default:       stall_pct = 0;
      endcase
      out_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // Hold the output off for a long stretch so the block backs up its input
  initial begin : output_hold_off
    @(posedge clk);
    while (total_requests == 0 || accepted_count * 6 < total_requests * 5) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : run_limit
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : run_control
    int pick, len;

    // Directed: ignored samples, supply drops, enable, discard, abort, re-enable
    push_request(REQ_SAMPLE, 10'h3FF, 1'b1);
    push_request(REQ_SAMPLE, 10'h000, 1'b0);
    push_request(REQ_BUTTON, 10'h3FF, 1'b0);
    push_request(REQ_SAMPLE, 10'h200, 1'b1);
    push_request(REQ_BUTTON, 10'h000, 1'b1);
    push_request(REQ_SAMPLE, 10'h3FF, 1'b1);
    push_request(REQ_SAMPLE, 10'h3FF, 1'b1);
    push_request(REQ_SAMPLE, 10'h000, 1'b1);
    push_request(REQ_SAMPLE, 10'h155, 1'b1);
    push_request(REQ_BUTTON, 10'h2AA, 1'b1);
    push_request(REQ_SAMPLE, 10'h3FF, 1'b1);
    push_request(REQ_BUTTON, 10'h155, 1'b1);
    push_request(REQ_SAMPLE, 10'h000, 1'b1);
    push_request(REQ_SAMPLE, 10'h3FF, 1'b1);
    push_request(REQ_SAMPLE, 10'h3FF, 1'b0);
    push_request(REQ_BUTTON, 10'h3FF, 1'b0);
    push_request(REQ_BUTTON, 10'h001, 1'b1);
    push_request(REQ_SAMPLE, 10'h3FE, 1'b1);
    push_request(REQ_SAMPLE, 10'h001, 1'b1);
    push_request(REQ_BUTTON, 10'h000, 1'b1);
    push_request(REQ_SAMPLE, 10'h000, 1'b1);
    push_request(REQ_BUTTON, 10'h3FF, 1'b1);

    // Random: mostly full averaging bursts, with aborts, toggles and supply drops
    while (effective_count < ITEM_TARGET || plan_averages < MIN_AVERAGES) begin
      pick = $urandom_range(99);
      if (!plan_scanning) begin
        if (pick < 12)
          push_request(REQ_SAMPLE, ADC_W'($urandom_range(1023)), 1'b1);
        else if (pick < 16)
          push_request(1'($urandom_range(1)), ADC_W'($urandom_range(1023)), 1'b0);
        else
          push_request(REQ_BUTTON, ADC_W'($urandom_range(1023)), 1'b1);
      end else if (pick < 75) begin
        push_burst(BURST_LEN - plan_progress);
      end else if (pick < 88) begin
        push_burst($urandom_range(1, 100));
      end else if (pick < 95) begin
        push_request(REQ_BUTTON, ADC_W'($urandom_range(1023)), 1'b1);
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) push_request(1'($urandom_range(1)), ADC_W'($urandom_range(1023)), 1'b0);
      end
    end
    total_requests = requests_to_send.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every request taken and every prediction matched
    while (accepted_count < total_requests || reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && reports_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
